@@ design/crsp_pkg.sv @@
// Shared constants and types for the Catmull-Rom spline point evaluator.
// No dependencies; every other design file imports this package.
package crsp_pkg;

  // Default field widths: signed Q16.16 coordinates, unsigned Q1.16 parameter
  localparam int CRSP_COORD_BITS  = 32;
  localparam int CRSP_T_FRAC_BITS = 16;

  // Register stages from input to output, output register included
  localparam int CRSP_NSTG = 7;

  // Per-stage load enables, shared by the lanes and the merge stage
  typedef struct packed {
    logic [CRSP_NSTG-1:0] en;
  } crsp_stage_en_t;

endpackage

@@ design/crsp_in_if.sv @@
// Request channel (control points and curve parameter) with valid/ready.
// Depends on crsp_pkg for default widths.
interface crsp_in_if
  import crsp_pkg::*;
#(
  parameter int COORD_BITS  = CRSP_COORD_BITS,
  parameter int T_FRAC_BITS = CRSP_T_FRAC_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p0_x;
  logic signed [COORD_BITS-1:0] p0_y;
  logic signed [COORD_BITS-1:0] p1_x;
  logic signed [COORD_BITS-1:0] p1_y;
  logic signed [COORD_BITS-1:0] p2_x;
  logic signed [COORD_BITS-1:0] p2_y;
  logic signed [COORD_BITS-1:0] p3_x;
  logic signed [COORD_BITS-1:0] p3_y;
  logic        [T_FRAC_BITS:0]  param_t;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
    output ready
  );
endinterface

@@ design/crsp_out_if.sv @@
// Result channel (interpolated point and overflow flag) with valid/ready.
// Depends on crsp_pkg for default widths.
interface crsp_out_if
  import crsp_pkg::*;
#(
  parameter int COORD_BITS = CRSP_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         overflow;

  modport source (
    output valid, out_x, out_y, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, overflow,
    output ready
  );
endinterface

@@ design/crsp_ctrl.sv @@
// Pipeline valid tracking and per-stage enables with bubble collapsing.
// Depends on crsp_pkg.
module crsp_ctrl
  import crsp_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output crsp_stage_en_t stg
);

  logic [CRSP_NSTG-1:0] vld_r;
  logic [CRSP_NSTG:0]   rdy;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    rdy[CRSP_NSTG] = out_ready;
    for (int k = CRSP_NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign stg.en    = rdy[CRSP_NSTG-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[CRSP_NSTG-1];

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < CRSP_NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

endmodule

@@ design/crsp_lane.sv @@
// One axis of the spline: coefficients, Horner steps with split multiplies,
// rounding and saturation check. Depends on crsp_pkg.
module crsp_lane
  import crsp_pkg::*;
#(
  parameter int COORD_BITS  = CRSP_COORD_BITS,
  parameter int T_FRAC_BITS = CRSP_T_FRAC_BITS
)(
  input  logic                         clk,
  input  crsp_stage_en_t               stg,
  input  logic signed [COORD_BITS-1:0] q0,
  input  logic signed [COORD_BITS-1:0] q1,
  input  logic signed [COORD_BITS-1:0] q2,
  input  logic signed [COORD_BITS-1:0] q3,
  input  logic        [T_FRAC_BITS:0]  t_in,
  output logic signed [COORD_BITS-1:0] res,
  output logic                         sat
);

  localparam int CF_W = COORD_BITS + 4;                    // coefficient width
  localparam int T_W  = T_FRAC_BITS + 1;
  localparam int W1   = COORD_BITS + T_FRAC_BITS + 5;      // after first step
  localparam int W2   = COORD_BITS + 2 * T_FRAC_BITS + 5;  // after second step
  localparam int W3   = COORD_BITS + 3 * T_FRAC_BITS + 5;  // full sum
  localparam int L1   = W1 / 2;
  localparam int L2   = W2 / 2;
  localparam int V_W  = W3 - 3 * T_FRAC_BITS - 1;          // after rounding shift
  localparam int PL1_W = L1 + T_W;
  localparam int PH1_W = W1 - L1 + T_W + 1;
  localparam int PL2_W = L2 + T_W;
  localparam int PH2_W = W2 - L2 + T_W + 1;

  localparam logic [T_W-1:0]         T_ONE  = T_W'(1) << T_FRAC_BITS;
  localparam logic signed [CF_W-1:0] CF_ONE = CF_W'(1);
  localparam logic [COORD_BITS-1:0]  SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0]  SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [CF_W-1:0] q0e, q1e, q2e, q3e;
  logic signed [CF_W-1:0] ca_c, cb_c, cc_c, c0p_c;
  logic        [T_W-1:0]  t_c;

  logic signed [CF_W-1:0] ca0_r, cb0_r, cc0_r, c0p0_r;
  logic        [T_W-1:0]  t0_r;
  logic signed [W1-1:0]   s1_r;
  logic signed [CF_W-1:0] ca1_r, c0p1_r;
  logic        [T_W-1:0]  t1_r;
  logic        [PL1_W-1:0]        pl2_r;
  logic signed [PH1_W-1:0]        ph2_r;
  logic signed [CF_W-1:0] ca2_r, c0p2_r;
  logic        [T_W-1:0]  t2_r;
  logic signed [W2-1:0]   s2_r;
  logic signed [CF_W-1:0] c0p3_r;
  logic        [T_W-1:0]  t3_r;
  logic        [PL2_W-1:0]        pl4_r;
  logic signed [PH2_W-1:0]        ph4_r;
  logic signed [CF_W-1:0] c0p4_r;
  logic signed [W3-1:0]   s3_r;

  logic signed [CF_W+T_W:0]  prod1;
  logic signed [W1-1:0]      s1_nxt;
  logic signed [PH1_W-1:0]   ph2_nxt;
  logic        [PL1_W-1:0]   pl2_nxt;
  logic signed [W2-1:0]      s2_nxt;
  logic signed [PH2_W-1:0]   ph4_nxt;
  logic        [PL2_W-1:0]   pl4_nxt;
  logic signed [W3-1:0]      s3_nxt;
  logic signed [V_W-1:0]     v;
  logic [V_W-COORD_BITS:0]   v_top;

  // coefficients; c0p folds the rounding half into 2*p1 + 1
  assign q0e   = CF_W'(q0);
  assign q1e   = CF_W'(q1);
  assign q2e   = CF_W'(q2);
  assign q3e   = CF_W'(q3);
  assign ca_c  = q2e - q0e;
  assign cb_c  = (q0e <<< 1) - ((q1e <<< 2) + q1e) + (q2e <<< 2) - q3e;
  assign cc_c  = ((q1e <<< 1) + q1e) - q0e - ((q2e <<< 1) + q2e) + q3e;
  assign c0p_c = (q1e <<< 1) + CF_ONE;
  assign t_c   = (t_in > T_ONE) ? T_ONE : t_in;

  // first Horner step: cc*t + cb*one
  assign prod1  = cc0_r * $signed({1'b0, t0_r});
  assign s1_nxt = W1'(prod1) + (W1'(cb0_r) <<< T_FRAC_BITS);

  // second step, multiply split into low and high halves
  assign pl2_nxt = PL1_W'(s1_r[L1-1:0] * t1_r);
  assign ph2_nxt = $signed(s1_r[W1-1:L1]) * $signed({1'b0, t1_r});
  assign s2_nxt  = (W2'(ph2_r) <<< L1) + W2'($signed({1'b0, pl2_r}))
                 + (W2'(ca2_r) <<< (2 * T_FRAC_BITS));

  // third step, same split
  assign pl4_nxt = PL2_W'(s2_r[L2-1:0] * t3_r);
  assign ph4_nxt = $signed(s2_r[W2-1:L2]) * $signed({1'b0, t3_r});
  assign s3_nxt  = (W3'(ph4_r) <<< L2) + W3'($signed({1'b0, pl4_r}))
                 + (W3'(c0p4_r) <<< (3 * T_FRAC_BITS));

  // halve, drop fraction bits, saturate
  assign v     = s3_r[W3-1:3*T_FRAC_BITS+1];
  assign v_top = v[V_W-1:COORD_BITS-1];
  assign sat   = !((&v_top) || (~|v_top));
  assign res   = sat ? (v[V_W-1] ? SAT_MIN : SAT_MAX) : v[COORD_BITS-1:0];

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (stg.en[0]) begin
      ca0_r  <= ca_c;
      cb0_r  <= cb_c;
      cc0_r  <= cc_c;
      c0p0_r <= c0p_c;
      t0_r   <= t_c;
    end
    if (stg.en[1]) begin
      s1_r   <= s1_nxt;
      ca1_r  <= ca0_r;
      c0p1_r <= c0p0_r;
      t1_r   <= t0_r;
    end
    if (stg.en[2]) begin
      pl2_r  <= pl2_nxt;
      ph2_r  <= ph2_nxt;
      ca2_r  <= ca1_r;
      c0p2_r <= c0p1_r;
      t2_r   <= t1_r;
    end
    if (stg.en[3]) begin
      s2_r   <= s2_nxt;
      c0p3_r <= c0p2_r;
      t3_r   <= t2_r;
    end
    if (stg.en[4]) begin
      pl4_r  <= pl4_nxt;
      ph4_r  <= ph4_nxt;
      c0p4_r <= c0p3_r;
    end
    if (stg.en[5]) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

@@ design/crsp_merge.sv @@
// Output stage: joins the two axis lanes and the overflow flags into one
// registered result. Depends on crsp_pkg.
module crsp_merge
  import crsp_pkg::*;
#(
  parameter int COORD_BITS = CRSP_COORD_BITS
)(
  input  logic                         clk,
  input  crsp_stage_en_t               stg,
  input  logic signed [COORD_BITS-1:0] res_x,
  input  logic signed [COORD_BITS-1:0] res_y,
  input  logic                         sat_x,
  input  logic                         sat_y,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         overflow
);

  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic                         ovf_r;

  // result register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (stg.en[CRSP_NSTG-1]) begin
      x_r   <= res_x;
      y_r   <= res_y;
      ovf_r <= sat_x | sat_y;
    end
  end

  assign out_x    = x_r;
  assign out_y    = y_r;
  assign overflow = ovf_r;

endmodule

@@ design/catmull_rom_spline_point.sv @@
// Top level of the uniform Catmull-Rom spline point evaluator (2D).
// Depends on crsp_pkg, crsp_in_if, crsp_out_if, crsp_ctrl, crsp_lane, crsp_merge.
//
//   port    | dir | handshake    | carries
//   --------+-----+--------------+----------------------------------------
//   in_ch   | in  | valid/ready  | p0..p3 x/y (signed Q16.16), param_t
//   out_ch  | out | valid/ready  | out_x, out_y (signed Q16.16), overflow
//
// One request per cycle sustained while out_ch.ready stays high. Each request
// passes the split Horner multiplies of both axis lanes and the result register.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// Empty stages fill while the output stalls, so up to 7 requests are taken
// before in_ch.ready drops.
module catmull_rom_spline_point
  import crsp_pkg::*;
#(
  parameter int COORD_BITS  = CRSP_COORD_BITS,
  parameter int T_FRAC_BITS = CRSP_T_FRAC_BITS
)(
  input  logic        clk,
  input  logic        rst_n,
  crsp_in_if.sink     in_ch,
  crsp_out_if.source  out_ch
);

  crsp_stage_en_t               stg;
  logic signed [COORD_BITS-1:0] res_x, res_y;
  logic                         sat_x, sat_y;

  // valid tracking and stage enables
  crsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stg       (stg)
  );

  // x axis
  crsp_lane #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lane_x (
    .clk  (clk),
    .stg  (stg),
    .q0   (in_ch.p0_x),
    .q1   (in_ch.p1_x),
    .q2   (in_ch.p2_x),
    .q3   (in_ch.p3_x),
    .t_in (in_ch.param_t),
    .res  (res_x),
    .sat  (sat_x)
  );

  // y axis
  crsp_lane #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lane_y (
    .clk  (clk),
    .stg  (stg),
    .q0   (in_ch.p0_y),
    .q1   (in_ch.p1_y),
    .q2   (in_ch.p2_y),
    .q3   (in_ch.p3_y),
    .t_in (in_ch.param_t),
    .res  (res_y),
    .sat  (sat_y)
  );

  // joined result register
  crsp_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk      (clk),
    .stg      (stg),
    .res_x    (res_x),
    .res_y    (res_y),
    .sat_x    (sat_x),
    .sat_y    (sat_y),
    .out_x    (out_ch.out_x),
    .out_y    (out_ch.out_y),
    .overflow (out_ch.overflow)
  );

endmodule
